// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define HAC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define HAC_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
		else $error(msg);

`endif

// ===== design/hac_pkg.sv =====
// ----------------------------------------------------------------------------
// Heading arctangent package
// Fixed widths, constants and shared types of the heading block.
// ----------------------------------------------------------------------------
package hac_pkg;

	localparam int ANGLE_W = 25;
	localparam int M_TDATA_W = 32;
	localparam int TERMS_W = 5;
	localparam logic [TERMS_W-1:0] TERMS_RESET = 5'd20;
	localparam int DEG_Q = 24;
	localparam int DEG_SCALE_BITS = 16;
	localparam int HALF_TURN_DEG = 180;
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_TURN = 25'sd11796480;
	localparam logic signed [ANGLE_W-1:0] ANGLE_QUARTER = 25'sd5898240;

	typedef struct packed {
		logic zero_div;
		logic dx_pos;
		logic dx_neg;
		logic dy_neg;
		logic neg;
		logic swap;
	} hac_flags_t;

	localparam int FLAGS_W = $bits(hac_flags_t);

endpackage

// ===== design/hac_front.sv =====
// ----------------------------------------------------------------------------
// Heading front end
// Accepts coordinate words, takes magnitudes and classifies each item.
// ----------------------------------------------------------------------------
module hac_front #(
	parameter int COORD_WIDTH = 21
) (
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [COORD_WIDTH-1:0]    dx,
	input  logic [COORD_WIDTH-1:0]    dy,
	input  logic                      q_full,
	output logic                      push,
	output hac_pkg::hac_flags_t       flags,
	output logic [COORD_WIDTH-1:0]    num_mag,
	output logic [COORD_WIDTH-1:0]    den_mag
);
	import hac_pkg::*;

	logic [COORD_WIDTH-1:0] ax;
	logic [COORD_WIDTH-1:0] ay;
	logic                   swap;

	assign s_tready = !q_full;
	assign push = s_tvalid && !q_full;

	assign ax = dx[COORD_WIDTH-1] ? COORD_WIDTH'(-dx) : dx;
	assign ay = dy[COORD_WIDTH-1] ? COORD_WIDTH'(-dy) : dy;
	assign swap = ax > ay;

	always_comb begin
		flags.zero_div = (dy == '0);
		flags.dx_pos = !dx[COORD_WIDTH-1] && (dx != '0);
		flags.dx_neg = dx[COORD_WIDTH-1];
		flags.dy_neg = dy[COORD_WIDTH-1];
		flags.neg = (dx[COORD_WIDTH-1] != dy[COORD_WIDTH-1]) && (dx != '0);
		flags.swap = swap;
	end

	assign num_mag = swap ? ay : ax;
	assign den_mag = swap ? ax : ay;

endmodule

// ===== design/hac_queue.sv =====
// ----------------------------------------------------------------------------
// Heading item queue
// Two-entry queue between the front end and the evaluation engine.
// ----------------------------------------------------------------------------
module hac_queue #(
	parameter int WIDTH = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	import hac_pkg::*;

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== design/hac_div.sv =====
// ----------------------------------------------------------------------------
// Heading divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hac_div #(
	parameter int RW = 32,
	parameter int FW = 27,
	parameter int CNTW = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [RW-1:0]   rem0,
	input  logic [FW-1:0]   feed,
	input  logic [CNTW-1:0] count,
	input  logic [RW-1:0]   den,
	output logic            done,
	output logic [FW-1:0]   quo
);
	import hac_pkg::*;

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [RW-1:0]   rem_q;
	logic [FW-1:0]   feed_q;
	logic [RW-1:0]   den_q;
	logic [FW-1:0]   quo_q;
	logic [RW-1:0]   r2;
	logic            ge;

	assign r2 = {rem_q[RW-2:0], feed_q[FW-1]};
	assign ge = (r2 >= den_q);
	assign done = done_q;
	assign quo = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem0;
			feed_q <= feed;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? RW'(r2 - den_q) : r2;
			feed_q <= {feed_q[FW-2:0], 1'b0};
			quo_q <= {quo_q[FW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= count;
			end else if (busy_q) begin
				cnt_q <= CNTW'(cnt_q - 1'b1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== design/hac_back.sv =====
// ----------------------------------------------------------------------------
// Heading evaluation engine
// Sequences the ratio, continued fraction, degree conversion and quadrant.
// ----------------------------------------------------------------------------
module hac_back #(
	parameter int COORD_WIDTH = 21,
	parameter int FRAC_BITS = 22,
	parameter int TERM_W = 5
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic [TERM_W-1:0]                          n_terms,
	input  logic                                       q_empty,
	input  logic [hac_pkg::FLAGS_W+2*COORD_WIDTH-1:0]  q_data,
	output logic                                       pop,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	output logic [hac_pkg::ANGLE_W-1:0]                angle,
	output logic                                       zero_divisor
);
	import hac_pkg::*;

	localparam int F = FRAC_BITS;
	localparam int CW = COORD_WIDTH;
	localparam int DW = F + TERM_W + 2;
	localparam int NUMW = 2 * TERM_W + F + 1;
	localparam int DENW = (DW > CW) ? DW : CW;
	localparam int RW = DENW + 1;
	localparam int FW = (F + TERM_W > DEG_Q) ? F + TERM_W : DEG_Q;
	localparam int CNTW = $clog2(FW + 1);
	localparam int AW = F + 1;
	localparam int XW = F + 26;
	localparam int PSH = 60 - F;
	localparam logic [63:0] PI_R = (PI_Q60 + (64'd1 << (PSH - 1))) >> PSH;
	localparam logic [F+1:0] PIF = PI_R[F+1:0];
	localparam logic [F:0] PIF_HALF = PIF[F+1:1];
	localparam int RC_SH = 32;
	localparam logic [63:0] DEG_K = 64'(HALF_TURN_DEG) << DEG_SCALE_BITS;
	localparam logic [63:0] RC_W = (DEG_K << RC_SH) / 64'(PIF);
	localparam int RCW = $clog2(RC_W + 64'd1);
	localparam logic [RCW-1:0] RC = RC_W[RCW-1:0];
	localparam int PW = AW + RCW;
	localparam int MW = F + 4;
	localparam logic [MW-1:0] PIF_M = MW'(PIF);
	localparam logic [MW-1:0] PIF2_M = MW'(PIF) << 1;

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_T_GO  = 14'b00000000000010,
		ST_T_W   = 14'b00000000000100,
		ST_SQ    = 14'b00000000001000,
		ST_K_SQ  = 14'b00000000010000,
		ST_K_MUL = 14'b00000000100000,
		ST_K_GO  = 14'b00000001000000,
		ST_K_W   = 14'b00000010000000,
		ST_F_GO  = 14'b00000100000000,
		ST_F_W   = 14'b00001000000000,
		ST_D_MUL = 14'b00010000000000,
		ST_D_GO  = 14'b00100000000000,
		ST_D_W   = 14'b01000000000000,
		ST_EMIT  = 14'b10000000000000
	} state_t;

	state_t                      state_q;
	hac_flags_t                  flags_q;
	logic [CW-1:0]               a_q;
	logic [CW-1:0]               b_q;
	logic [F:0]                  t_q;
	logic [F:0]                  x2_q;
	logic [TERM_W-1:0]           k_q;
	logic [2*TERM_W-1:0]         kk_q;
	logic [NUMW-1:0]             num_q;
	logic [DW-1:0]               d_q;
	logic [AW-1:0]               at_q;
	logic [XW-1:0]               x_q;
	logic [DEG_Q-1:0]            qe_q;
	logic [MW-1:0]               rem_q;
	logic signed [ANGLE_W-1:0]   res_q;
	logic                        out_valid_q;
	logic [ANGLE_W-1:0]          angle_q;
	logic                        zd_q;

	hac_flags_t                  q_flags;
	logic                        div_start;
	logic [RW-1:0]               div_rem0;
	logic [FW-1:0]               div_feed;
	logic [CNTW-1:0]             div_cnt;
	logic [RW-1:0]               div_den;
	logic                        div_done;
	logic [FW-1:0]               div_quo;
	logic [2*F+1:0]              tsq;
	logic [PW-1:0]               qe_prod;
	logic [DEG_Q-1:0]            q_fix;
	logic signed [ANGLE_W-1:0]   mag_s;
	logic signed [ANGLE_W-1:0]   sgn_s;
	logic signed [ANGLE_W-1:0]   quad_s;
	logic signed [ANGLE_W-1:0]   fall_s;
	logic                        out_free;

	assign q_flags = hac_flags_t'(q_data[FLAGS_W+2*CW-1:2*CW]);
	assign pop = (state_q == ST_IDLE) && !q_empty;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign angle = angle_q;
	assign zero_divisor = zd_q;
	assign tsq = (2*F+2)'(t_q) * (2*F+2)'(t_q);
	assign qe_prod = PW'(at_q) * PW'(RC);

	always_comb begin
		div_start = 1'b0;
		div_rem0 = '0;
		div_feed = '0;
		div_cnt = '0;
		div_den = '0;
		case (state_q)
			ST_T_GO: begin
				div_start = 1'b1;
				div_rem0 = RW'(a_q >> 1);
				div_feed = FW'({a_q[0], {F{1'b0}}}) << (FW - F - 1);
				div_cnt = CNTW'(F + 1);
				div_den = RW'(b_q);
			end
			ST_K_GO: begin
				div_start = 1'b1;
				div_rem0 = RW'(num_q >> TERM_W);
				div_feed = FW'({num_q[TERM_W-1:0], {F{1'b0}}}) << (FW - F - TERM_W);
				div_cnt = CNTW'(F + TERM_W);
				div_den = RW'(d_q);
			end
			ST_F_GO: begin
				div_start = 1'b1;
				div_rem0 = RW'(t_q >> 1);
				div_feed = FW'({t_q[0], {F{1'b0}}}) << (FW - F - 1);
				div_cnt = CNTW'(F + 1);
				div_den = RW'(d_q);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// The reciprocal estimate is at most two below the true quotient.
	always_comb begin
		if (rem_q >= PIF2_M) begin
			q_fix = DEG_Q'(qe_q + 2'd2);
		end else if (rem_q >= PIF_M) begin
			q_fix = DEG_Q'(qe_q + 1'b1);
		end else begin
			q_fix = qe_q;
		end
		mag_s = $signed(ANGLE_W'(q_fix));
		sgn_s = flags_q.neg ? -mag_s : mag_s;
		if (flags_q.dy_neg) begin
			quad_s = flags_q.dx_neg ? sgn_s - ANGLE_HALF_TURN : sgn_s + ANGLE_HALF_TURN;
		end else begin
			quad_s = sgn_s;
		end
		if (q_flags.dx_pos) begin
			fall_s = ANGLE_QUARTER;
		end else if (q_flags.dx_neg) begin
			fall_s = -ANGLE_QUARTER;
		end else begin
			fall_s = '0;
		end
	end

	hac_div #(
		.RW(RW),
		.FW(FW),
		.CNTW(CNTW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.rem0(div_rem0),
		.feed(div_feed),
		.count(div_cnt),
		.den(div_den),
		.done(div_done),
		.quo(div_quo)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				flags_q <= q_flags;
				a_q <= q_data[2*CW-1:CW];
				b_q <= q_data[CW-1:0];
				res_q <= fall_s;
			end
			ST_T_W: begin
				t_q <= div_quo[F:0];
			end
			ST_SQ: begin
				x2_q <= tsq[2*F:F];
				k_q <= n_terms;
				d_q <= DW'({n_terms, 1'b1}) << F;
			end
			ST_K_SQ: begin
				kk_q <= (2*TERM_W)'(k_q) * (2*TERM_W)'(k_q);
			end
			ST_K_MUL: begin
				num_q <= NUMW'(kk_q) * NUMW'(x2_q);
			end
			ST_K_W: begin
				if (div_done) begin
					d_q <= DW'(DW'({TERM_W'(k_q - 1'b1), 1'b1}) << F) + DW'(div_quo);
					k_q <= TERM_W'(k_q - 1'b1);
				end
			end
			ST_F_W: begin
				if (div_done) begin
					at_q <= flags_q.swap ? AW'(PIF_HALF - div_quo[F:0]) : div_quo[F:0];
				end
			end
			ST_D_MUL: begin
				x_q <= XW'((XW'(at_q) * XW'(HALF_TURN_DEG)) << DEG_SCALE_BITS) + XW'(PIF_HALF);
				qe_q <= DEG_Q'(qe_prod >> RC_SH);
			end
			ST_D_GO: begin
				rem_q <= MW'(x_q - XW'(qe_q) * XW'(PIF));
			end
			ST_D_W: begin
				res_q <= quad_s;
			end
			default: begin
			end
		endcase
		if ((state_q == ST_EMIT) && out_free) begin
			angle_q <= res_q;
			zd_q <= flags_q.zero_div;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= q_flags.zero_div ? ST_EMIT : ST_T_GO;
					end
				end
				ST_T_GO: state_q <= ST_T_W;
				ST_T_W: begin
					if (div_done) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: state_q <= (n_terms == '0) ? ST_F_GO : ST_K_SQ;
				ST_K_SQ: state_q <= ST_K_MUL;
				ST_K_MUL: state_q <= ST_K_GO;
				ST_K_GO: state_q <= ST_K_W;
				ST_K_W: begin
					if (div_done) begin
						state_q <= (k_q == TERM_W'(1)) ? ST_F_GO : ST_K_SQ;
					end
				end
				ST_F_GO: state_q <= ST_F_W;
				ST_F_W: begin
					if (div_done) begin
						state_q <= ST_D_MUL;
					end
				end
				ST_D_MUL: state_q <= ST_D_GO;
				ST_D_GO: state_q <= ST_D_W;
				ST_D_W: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/heading_angle_arctan_cf.sv =====
// ----------------------------------------------------------------------------
// Heading angle by arctangent continued fraction
// An item with dy nonzero runs the ratio, each of its num_terms continued
// fraction terms and the final quotient through the one shared radix-2
// divider; a zero-divisor item skips the divider.
// Items are evaluated one at a time; a two-word queue keeps input words flowing.
// Reset is asynchronous, active low; num_terms returns to 20.
// ----------------------------------------------------------------------------
module heading_angle_arctan_cf #(
	parameter int COORD_WIDTH = 21,
	parameter int FRAC_BITS = 22,
	parameter int MAX_TERMS = 31
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// dx, dy
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// angle
	output logic [hac_pkg::M_TDATA_W-1:0]           m_tdata,
	// zero_divisor
	output logic                                    m_tuser,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [hac_pkg::TERMS_W-1:0]             cfg_data
);
	import hac_pkg::*;

	localparam int TERM_W = $clog2(MAX_TERMS + 1);
	localparam int NTW = (TERM_W > TERMS_W) ? TERM_W : TERMS_W;
	localparam int QW = FLAGS_W + 2 * COORD_WIDTH;

	logic [TERMS_W-1:0]     num_terms_q;
	logic [NTW-1:0]         nt_ext;
	logic [TERM_W-1:0]      n_terms;
	hac_flags_t             flags;
	logic [COORD_WIDTH-1:0] num_mag;
	logic [COORD_WIDTH-1:0] den_mag;
	logic                   push;
	logic                   pop;
	logic                   q_full;
	logic                   q_empty;
	logic [QW-1:0]          q_data;
	logic [ANGLE_W-1:0]     angle;

	assign cfg_ready = 1'b1;
	assign nt_ext = NTW'(num_terms_q);
	assign n_terms = (nt_ext > NTW'(MAX_TERMS)) ? TERM_W'(MAX_TERMS) : TERM_W'(nt_ext);
	assign m_tdata = M_TDATA_W'(angle);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_terms_q <= TERMS_RESET;
		end else if (cfg_valid) begin
			num_terms_q <= cfg_data;
		end
	end

	hac_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.dx(s_tdata[COORD_WIDTH-1:0]),
		.dy(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
		.q_full(q_full),
		.push(push),
		.flags(flags),
		.num_mag(num_mag),
		.den_mag(den_mag)
	);

	hac_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata({flags, num_mag, den_mag}),
		.full(q_full),
		.pop(pop),
		.rdata(q_data),
		.empty(q_empty)
	);

	hac_back #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS(FRAC_BITS),
		.TERM_W(TERM_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.n_terms(n_terms),
		.q_empty(q_empty),
		.q_data(q_data),
		.pop(pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.angle(angle),
		.zero_divisor(m_tuser)
	);

endmodule

// ===== design/hac_checker.sv =====
// ----------------------------------------------------------------------------
// Heading result checker
// Port-level checks on the result stream of the heading block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hac_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [hac_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic                           m_tuser
);
	import hac_pkg::*;

	logic signed [ANGLE_W-1:0] angle_w;

	assign angle_w = m_tdata[ANGLE_W-1:0];

	`HAC_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "Result word changed while stalled.")
	`HAC_ASSERT(a_fallback, clk, arst_n, m_tvalid && m_tuser |-> (angle_w == ANGLE_QUARTER || angle_w == -ANGLE_QUARTER || angle_w == '0), "Zero divisor word carries a value other than the fallback.")
	`HAC_ASSERT(a_range, clk, arst_n, m_tvalid |-> (angle_w <= ANGLE_HALF_TURN) && (angle_w >= -ANGLE_HALF_TURN), "Heading outside a half turn.")
	`HAC_ASSERT(a_pad, clk, arst_n, m_tvalid |-> (m_tdata[M_TDATA_W-1:ANGLE_W] == '0), "Padding bits of the result word are not zero.")

endmodule

bind heading_angle_arctan_cf hac_checker u_hac_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Heading angle block testbench
// Sends coordinate pairs over the input stream and predicts each heading
// word in fixed point. Every output word is checked against the oldest
// predicted heading. The term count is changed between phases while the
// block is idle. Random gaps and stalls are applied on both streams.
// ----------------------------------------------------------------------------
module tb_top;

	import hac_pkg::*;

	localparam int CW = 21;
	localparam int FB = 22;
	localparam longint CYCLE_LIMIT = 8000000;

	typedef struct {
		logic [ANGLE_W-1:0] angle;
		logic               zero_div;
	} heading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [TERMS_W-1:0] cfg_data = '0;

	heading_t heading_q[$];
	int unsigned terms = TERMS_RESET;
	int unsigned err_count = 0;
	int unsigned hold_cycles = 0;
	bit no_idle = 1'b0;
	longint cycles = 0;

	heading_angle_arctan_cf u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL heading_angle_arctan_cf");
			$finish;
		end
	end

	function automatic longint unsigned frac_div(longint unsigned num, longint unsigned den);
		return (num << FB) / den;
	endfunction

	function automatic heading_t predict_heading(logic signed [CW-1:0] dx,
			logic signed [CW-1:0] dy, int unsigned n);
		heading_t h;
		longint sdx, sdy, ang, unit;
		longint unsigned ax, ay, t, x2, d, at, mag, pif;
		bit swap;
		sdx = dx;
		sdy = dy;
		unit = 64'sd1 << DEG_SCALE_BITS;
		h.zero_div = 1'b0;
		if (sdy == 0) begin
			h.zero_div = 1'b1;
			ang = (sdx > 0) ? 90 * unit : (sdx < 0) ? -90 * unit : 0;
		end else begin
			ax = (sdx < 0) ? -sdx : sdx;
			ay = (sdy < 0) ? -sdy : sdy;
			pif = (PI_Q60 + (64'd1 << (59 - FB))) >> (60 - FB);
			swap = ax > ay;
			t = swap ? frac_div(ay, ax) : frac_div(ax, ay);
			x2 = (t * t) >> FB;
			d = (2 * n + 1) << FB;
			for (int k = n; k > 0; k--)
				d = ((2 * k - 1) << FB) + frac_div(k * k * x2, d);
			at = frac_div(t, d);
			if (swap)
				at = (pif >> 1) - at;
			mag = ((at * HALF_TURN_DEG) << DEG_SCALE_BITS);
			mag = (mag + (pif >> 1)) / pif;
			ang = mag;
			if (((sdx < 0) != (sdy < 0)) && sdx != 0)
				ang = -ang;
			if (sdy < 0)
				ang = (sdx >= 0) ? ang + HALF_TURN_DEG * unit : ang - HALF_TURN_DEG * unit;
		end
		h.angle = ang[ANGLE_W-1:0];
		return h;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		err_count++;
	endtask

	task automatic send_pair(logic signed [CW-1:0] dx, logic signed [CW-1:0] dy);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, dy, dx};
		do @(posedge clk); while (!s_tready);
		heading_q.push_back(predict_heading(dx, dy, terms));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (heading_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_terms(logic [TERMS_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		terms = v;
	endtask

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return CW'(int'($urandom_range(0, 15)) - 8);
			1: return CW'(int'($urandom_range(0, 2047)) - 1024);
			default: return CW'($urandom());
		endcase
	endfunction

	task automatic send_random_pair();
		logic signed [CW-1:0] dx, dy;
		dx = rand_coord();
		dy = rand_coord();
		case ($urandom_range(0, 9))
			0: dy = 0;
			1: dx = 0;
			2: dy = ($urandom_range(0, 1)) ? dx : -dx;
			default: ;
		endcase
		send_pair(dx, dy);
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else if (no_idle) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) < 80);
		end
	end

	always @(posedge clk) begin
		heading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (heading_q.size() == 0) begin
				report_mismatch("unexpected word", m_tdata, 0);
			end else begin
				want = heading_q.pop_front();
				if (m_tdata !== {{(M_TDATA_W-ANGLE_W){1'b0}}, want.angle})
					report_mismatch("angle", m_tdata, want.angle);
				if (m_tuser !== want.zero_div)
					report_mismatch("zero_divisor", m_tuser, want.zero_div);
			end
		end
	end

	task automatic test_directed();
		localparam logic signed [CW-1:0] MAXV = 21'sd1048575;
		localparam logic signed [CW-1:0] MINV = -21'sd1048576;
		send_pair(0, 0);
		send_pair(1, 0);
		send_pair(-1, 0);
		send_pair(MAXV, 0);
		send_pair(MINV, 0);
		send_pair(0, -5);
		send_pair(0, MINV);
		send_pair(0, MAXV);
		send_pair(5, 5);
		send_pair(-5, 5);
		send_pair(5, -5);
		send_pair(-5, -5);
		send_pair(MAXV, MINV);
		send_pair(MINV, MINV);
		send_pair(MINV, MAXV);
		send_pair(MAXV, MAXV);
		send_pair(1, MAXV);
		send_pair(MAXV, 1);
		send_pair(MINV, 1);
		send_pair(-1, MINV);
		send_pair(3, 4);
		send_pair(4, -3);
		send_pair(-21'sd699050, 21'sd349525);
		wait_drained();
	endtask

	task automatic test_term_extremes();
		logic [TERMS_W-1:0] settings[5] = '{5'd0, 5'd1, 5'd31, 5'd2, 5'd20};
		foreach (settings[i]) begin
			write_terms(settings[i]);
			send_pair(7, 3);
			send_pair(-3, 7);
			repeat (18) send_random_pair();
			wait_drained();
		end
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 10; p++) begin
			write_terms(TERMS_W'(($urandom_range(0, 3) == 0) ?
				$urandom_range(0, 31) : $urandom_range(0, 6)));
			no_idle = (p % 4 == 3);
			repeat (160) send_random_pair();
			wait_drained();
			no_idle = 1'b0;
		end
	endtask

	task automatic test_backpressure();
		write_terms(TERMS_W'(3));
		wait_drained();
		hold_cycles = 400;
		no_idle = 1'b1;
		repeat (12) send_random_pair();
		no_idle = 1'b0;
		wait_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_term_extremes();
		test_backpressure();
		test_random_phases();
		wait_drained();
		repeat (50) @(posedge clk);
		if (err_count == 0)
			$display("PASS heading_angle_arctan_cf");
		else
			$display("FAIL heading_angle_arctan_cf");
		$finish;
	end

endmodule
